[hw/rtl/ctt_pkg.sv]
// Shared types and codes for the config text tokenizer.
// Request and result payload structs, lexer mode enum, event/kind/error codes.
// No dependencies.
package ctt_pkg;

  localparam int unsigned MAX_RES    = 4;
  localparam int unsigned RES_IDX_W  = 2;
  localparam int unsigned RES_CNT_W  = 3;
  localparam int unsigned PORT_POS_W = 16;
  localparam logic [PORT_POS_W-1:0] PORT_POS_MAX = 16'hFFFF;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic [1:0] EV_CONTENT = 2'd0;
  localparam logic [1:0] EV_TOKEN   = 2'd1;
  localparam logic [1:0] EV_ERROR   = 2'd2;

  localparam logic [3:0] KIND_WORD     = 4'd0;
  localparam logic [3:0] KIND_STRING   = 4'd1;
  localparam logic [3:0] KIND_LBRACE   = 4'd2;
  localparam logic [3:0] KIND_RBRACE   = 4'd3;
  localparam logic [3:0] KIND_LBRACKET = 4'd4;
  localparam logic [3:0] KIND_RBRACKET = 4'd5;
  localparam logic [3:0] KIND_SEMI     = 4'd6;
  localparam logic [3:0] KIND_COMMA    = 4'd7;
  localparam logic [3:0] KIND_END      = 4'd8;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_CTRL_WORD    = 2'd0;
  localparam logic [1:0] ERR_UNTERM_STR   = 2'd1;
  localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd2;
  localparam logic [1:0] ERR_CTRL_STRING  = 2'd3;

  typedef enum logic [2:0] {
    M_BOM  = 3'd0,
    M_IDLE = 3'd1,
    M_WORD = 3'd2,
    M_STR  = 3'd3,
    M_ESC  = 3'd4,
    M_CMT  = 3'd5
  } lex_mode_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } ctt_in_t;

  typedef struct packed {
    logic [1:0]            event_res;
    logic [3:0]            token_kind;
    logic [7:0]            value_byte;
    logic [PORT_POS_W-1:0] line_no;
    logic [PORT_POS_W-1:0] column_no;
    logic [1:0]            error_code;
    logic                  last;
  } ctt_out_t;

  typedef struct packed {
    ctt_out_t [MAX_RES-1:0] res;
    logic [RES_CNT_W-1:0]   cnt;
  } ctt_bundle_t;

endpackage

[hw/rtl/ctt_lexer.sv]
// Lexer stage: request register, lexer state and the one-pass step logic.
// Produces a bundle of up to four results per request for ctt_serializer.
// Depends on ctt_pkg.
module ctt_lexer #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ctt_pkg::ctt_in_t  in_data,
  output logic              bundle_valid,
  output ctt_pkg::ctt_bundle_t bundle,
  input  logic              can_load
);
  import ctt_pkg::*;

  typedef logic [POS_BITS-1:0] pos_t;
  localparam pos_t POS_ONE = POS_BITS'(1);

  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] BOM_B0    = 8'hEF;
  localparam logic [7:0] BOM_B1    = 8'hBB;
  localparam logic [7:0] BOM_B2    = 8'hBF;

  ctt_in_t   in_r;
  logic      in_valid_r;
  logic      consume;

  lex_mode_t mode_r, mode_nxt;
  logic [1:0] bm_r, bm_nxt;
  logic      cr_r, cr_nxt;
  logic      failed_r, failed_nxt;
  pos_t      line_r, line_nxt;
  pos_t      col_r, col_nxt;
  pos_t      tline_r, tline_nxt;
  pos_t      tcol_r, tcol_nxt;

  ctt_out_t [MAX_RES-1:0] res;
  logic [RES_CNT_W-1:0]   cnt;
  logic      do_idle;
  logic      idle_cr;
  logic      bom_done;
  logic [7:0] b;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + POS_ONE;
  endfunction

  function automatic logic [PORT_POS_W-1:0] clamp_pos(input pos_t v);
    return (v > POS_BITS'(PORT_POS_MAX)) ? PORT_POS_MAX : PORT_POS_W'(v);
  endfunction

  function automatic ctt_out_t mk(input logic [1:0] ev, input logic [3:0] kind,
                                  input logic [7:0] val, input pos_t ln, input pos_t cl,
                                  input logic [1:0] err);
    ctt_out_t r;
    r.event_res  = ev;
    r.token_kind = kind;
    r.value_byte = val;
    r.line_no    = clamp_pos(ln);
    r.column_no  = clamp_pos(cl);
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h7B:   return KIND_LBRACE;
      8'h7D:   return KIND_RBRACE;
      8'h5B:   return KIND_LBRACKET;
      8'h5D:   return KIND_RBRACKET;
      8'h3B:   return KIND_SEMI;
      8'h2C:   return KIND_COMMA;
      default: return KIND_WORD;
    endcase
  endfunction

  function automatic logic ends_word(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_QUOTE) || (c == CH_HASH) || (punct_kind(c) != KIND_WORD);
  endfunction

  assign b = in_r.data_byte;

  always_comb begin
    mode_nxt   = mode_r;
    bm_nxt     = bm_r;
    cr_nxt     = cr_r;
    failed_nxt = failed_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    tline_nxt  = tline_r;
    tcol_nxt   = tcol_r;
    res        = '0;
    cnt        = '0;
    do_idle    = 1'b0;
    idle_cr    = 1'b0;
    bom_done   = 1'b0;

    if (!failed_r) begin
      if (in_r.func == FUNC_DATA) begin
        cr_nxt = 1'b0;
        if (mode_r == M_BOM) begin
          if ((bm_r == 2'd0 && b == BOM_B0) || (bm_r == 2'd1 && b == BOM_B1)) begin
            bm_nxt   = bm_r + 2'd1;
            bom_done = 1'b1;
          end else if (bm_r == 2'd2 && b == BOM_B2) begin
            bm_nxt   = 2'd0;
            mode_nxt = M_IDLE;
            bom_done = 1'b1;
          end
        end
      end

      // replay a partial byte order mark as word content
      if (mode_r == M_BOM && !bom_done) begin
        if (bm_r != 2'd0) begin
          tline_nxt = POS_ONE;
          tcol_nxt  = POS_ONE;
          mode_nxt  = M_WORD;
          res[cnt[RES_IDX_W-1:0]] = mk(EV_CONTENT, KIND_WORD, BOM_B0, POS_ONE, POS_ONE,
                                       ERR_NONE);
          cnt     = cnt + 3'd1;
          col_nxt = sat_inc(col_nxt);
          if (bm_r != 2'd1) begin
            res[cnt[RES_IDX_W-1:0]] = mk(EV_CONTENT, KIND_WORD, BOM_B1, POS_ONE, POS_ONE,
                                         ERR_NONE);
            cnt     = cnt + 3'd1;
            col_nxt = sat_inc(col_nxt);
          end
        end else begin
          mode_nxt = M_IDLE;
        end
        bm_nxt = 2'd0;
      end

      if (in_r.func == FUNC_END) begin
        if (mode_nxt == M_STR || mode_nxt == M_ESC) begin
          res[cnt[RES_IDX_W-1:0]] = mk(EV_ERROR, KIND_WORD, 8'h00, tline_nxt, tcol_nxt,
                                       ERR_UNTERM_STR);
          cnt        = cnt + 3'd1;
          failed_nxt = 1'b1;
        end else begin
          if (mode_nxt == M_WORD) begin
            res[cnt[RES_IDX_W-1:0]] = mk(EV_TOKEN, KIND_WORD, 8'h00, tline_nxt, tcol_nxt,
                                         ERR_NONE);
            cnt = cnt + 3'd1;
          end
          res[cnt[RES_IDX_W-1:0]] = mk(EV_TOKEN, KIND_END, 8'h00, line_nxt, col_nxt,
                                       ERR_NONE);
          cnt        = cnt + 3'd1;
          mode_nxt   = M_BOM;
          bm_nxt     = 2'd0;
          cr_nxt     = 1'b0;
          failed_nxt = 1'b0;
          line_nxt   = POS_ONE;
          col_nxt    = POS_ONE;
          tline_nxt  = POS_ONE;
          tcol_nxt   = POS_ONE;
        end
      end else if (!bom_done) begin
        unique case (mode_nxt)
          M_WORD: begin
            if (ends_word(b)) begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_TOKEN, KIND_WORD, 8'h00, tline_nxt, tcol_nxt,
                                           ERR_NONE);
              cnt     = cnt + 3'd1;
              do_idle = 1'b1;
            end else if (b < CH_SP) begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_ERROR, KIND_WORD, 8'h00, line_nxt, col_nxt,
                                           ERR_CTRL_WORD);
              cnt        = cnt + 3'd1;
              failed_nxt = 1'b1;
            end else begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_CONTENT, KIND_WORD, b, tline_nxt, tcol_nxt,
                                           ERR_NONE);
              cnt     = cnt + 3'd1;
              col_nxt = sat_inc(col_nxt);
            end
          end
          M_STR: begin
            if (b == CH_QUOTE) begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_TOKEN, KIND_STRING, 8'h00, tline_nxt,
                                           tcol_nxt, ERR_NONE);
              cnt      = cnt + 3'd1;
              col_nxt  = sat_inc(col_nxt);
              mode_nxt = M_IDLE;
            end else if (b == CH_BSLASH) begin
              mode_nxt = M_ESC;
            end else if (b < CH_SP) begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_ERROR, KIND_WORD, 8'h00, line_nxt, col_nxt,
                                           ERR_CTRL_STRING);
              cnt        = cnt + 3'd1;
              failed_nxt = 1'b1;
            end else begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_CONTENT, KIND_STRING, b, tline_nxt, tcol_nxt,
                                           ERR_NONE);
              cnt     = cnt + 3'd1;
              col_nxt = sat_inc(col_nxt);
            end
          end
          M_ESC: begin
            if (b == CH_QUOTE || b == CH_BSLASH || b == CH_N || b == CH_T) begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_CONTENT, KIND_STRING,
                                           (b == CH_N) ? CH_LF : ((b == CH_T) ? CH_TAB : b),
                                           tline_nxt, tcol_nxt, ERR_NONE);
              cnt      = cnt + 3'd1;
              col_nxt  = sat_inc(sat_inc(col_nxt));
              mode_nxt = M_STR;
            end else begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_ERROR, KIND_WORD, 8'h00, line_nxt, col_nxt,
                                           ERR_BAD_ESCAPE);
              cnt        = cnt + 3'd1;
              failed_nxt = 1'b1;
            end
          end
          M_CMT: begin
            if (b == CH_CR || b == CH_LF) begin
              do_idle = 1'b1;
            end else begin
              col_nxt = sat_inc(col_nxt);
            end
          end
          default: begin
            do_idle = 1'b1;
            idle_cr = cr_r;
          end
        endcase

        if (do_idle) begin
          mode_nxt = M_IDLE;
          if (!(b == CH_LF && idle_cr)) begin
            if (b == CH_SP || b == CH_TAB) begin
              col_nxt = sat_inc(col_nxt);
            end else if (b == CH_CR || b == CH_LF) begin
              line_nxt = sat_inc(line_nxt);
              col_nxt  = POS_ONE;
              cr_nxt   = (b == CH_CR);
            end else if (b == CH_HASH) begin
              mode_nxt = M_CMT;
              col_nxt  = sat_inc(col_nxt);
            end else if (b == CH_QUOTE) begin
              tline_nxt = line_nxt;
              tcol_nxt  = col_nxt;
              mode_nxt  = M_STR;
              col_nxt   = sat_inc(col_nxt);
            end else if (punct_kind(b) != KIND_WORD) begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_TOKEN, punct_kind(b), 8'h00, line_nxt,
                                           col_nxt, ERR_NONE);
              cnt     = cnt + 3'd1;
              col_nxt = sat_inc(col_nxt);
            end else if (b < CH_SP) begin
              res[cnt[RES_IDX_W-1:0]] = mk(EV_ERROR, KIND_WORD, 8'h00, line_nxt, col_nxt,
                                           ERR_CTRL_WORD);
              cnt        = cnt + 3'd1;
              failed_nxt = 1'b1;
            end else begin
              tline_nxt = line_nxt;
              tcol_nxt  = col_nxt;
              mode_nxt  = M_WORD;
              res[cnt[RES_IDX_W-1:0]] = mk(EV_CONTENT, KIND_WORD, b, line_nxt, col_nxt,
                                           ERR_NONE);
              cnt     = cnt + 3'd1;
              col_nxt = sat_inc(col_nxt);
            end
          end
        end
      end
    end
  end

  assign bundle_valid = in_valid_r && (cnt != '0);
  assign bundle.res   = res;
  assign bundle.cnt   = cnt;
  assign consume      = in_valid_r && ((cnt == '0) || can_load);
  assign in_stall     = in_valid_r && !consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_BOM;
      bm_r     <= 2'd0;
      cr_r     <= 1'b0;
      failed_r <= 1'b0;
      line_r   <= POS_ONE;
      col_r    <= POS_ONE;
      tline_r  <= POS_ONE;
      tcol_r   <= POS_ONE;
    end else if (consume) begin
      mode_r   <= mode_nxt;
      bm_r     <= bm_nxt;
      cr_r     <= cr_nxt;
      failed_r <= failed_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      tline_r  <= tline_nxt;
      tcol_r   <= tcol_nxt;
    end
  end

`ifndef SYNTHESIS
  ap_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> !bundle_valid)
    else $error("ctt_lexer: result produced after error");
  ap_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> failed_r)
    else $error("ctt_lexer: error flag cleared without reset");
  ap_cr_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cr_r |-> (mode_r == M_IDLE))
    else $error("ctt_lexer: pending CR outside idle mode");
`endif

endmodule

[hw/rtl/ctt_serializer.sv]
// Result register: holds one bundle of up to four results and emits one per cycle
// while out_stall is low. Marks the final result of each request with last.
// Depends on ctt_pkg.
module ctt_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 bundle_valid,
  input  ctt_pkg::ctt_bundle_t bundle,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ctt_pkg::ctt_out_t    out_data
);
  import ctt_pkg::*;

  ctt_bundle_t          bundle_r;
  logic                 bvalid_r;
  logic [RES_IDX_W-1:0] idx_r;
  logic                 at_last;

  assign at_last   = ({1'b0, idx_r} == (bundle_r.cnt - 3'd1));
  assign can_load  = !bvalid_r || (!out_stall && at_last);
  assign out_valid = bvalid_r;

  always_comb begin
    out_data      = bundle_r.res[idx_r];
    out_data.last = at_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
      idx_r    <= '0;
    end else if (bundle_valid && can_load) begin
      bvalid_r <= 1'b1;
      idx_r    <= '0;
    end else if (bvalid_r && !out_stall) begin
      if (at_last) begin
        bvalid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_valid && can_load) begin
      bundle_r <= bundle;
    end
  end

`ifndef SYNTHESIS
  ap_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    bvalid_r |-> (bundle_r.cnt != '0))
    else $error("ctt_serializer: empty bundle held");
  ap_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    bvalid_r |-> ({1'b0, idx_r} < bundle_r.cnt))
    else $error("ctt_serializer: index past bundle count");
  ap_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("ctt_serializer: stalled result changed");
`endif

endmodule

[hw/rtl/config_text_tokenizer.sv]
// Config text tokenizer, top level: ctt_lexer followed by ctt_serializer.
// Depends on ctt_pkg, ctt_lexer, ctt_serializer.
//
// Usage: feed one request per byte of the text on in_data (func = data byte),
// then one request with func = end of input. Results come out on out_data:
// content bytes of words and strings, completed tokens with start line and
// column, and sticky errors; last marks the final result of a request.
// A request is taken at a rising edge with in_valid high and in_stall low;
// a result is taken at an edge with out_valid high and out_stall low.
// A request is held in the request register, then its results in the result
// register. Throughput: one request per cycle when each gives at most one
// result and out_stall is low; a request giving k results (k up to 4) holds
// the single result register until all k are taken, and the next request
// giving results waits meanwhile. Requests giving none pass straight on.
// Reset (rst_n low, synchronous) empties both registers and returns the
// lexer to its start-of-text state. While out_stall is high the current
// result holds, and in_stall rises once the request register cannot drain.
module config_text_tokenizer #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ctt_pkg::ctt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ctt_pkg::ctt_out_t out_data
);
  import ctt_pkg::*;

  ctt_bundle_t bundle;
  logic        bundle_valid;
  logic        can_load;

  ctt_lexer #(
    .POS_BITS(POS_BITS)
  ) u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .bundle_valid(bundle_valid),
    .bundle      (bundle),
    .can_load    (can_load)
  );

  ctt_serializer u_serializer (
    .clk         (clk),
    .rst_n       (rst_n),
    .bundle_valid(bundle_valid),
    .bundle      (bundle),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

[tb/tb_config_text_tokenizer.sv]
// Self-checking testbench for config_text_tokenizer: drives byte/end requests and checks
// every token event against a cycle-free lexer predictor kept inside this module.
// Depends on ctt_pkg and config_text_tokenizer.
module tb_config_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import ctt_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned MAX_REPORTS  = 40;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] BOM_B0      = 8'hEF;
  localparam logic [7:0] BOM_B1      = 8'hBB;
  localparam logic [7:0] BOM_B2      = 8'hBF;
  localparam logic [7:0] CTRL_LIMIT  = 8'h20;

  typedef struct packed {
    logic    sync;
    ctt_in_t req;
  } text_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ctt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ctt_out_t out_data;

  text_item_t text_q[$];
  ctt_out_t   token_events_q[$];

  lex_mode_t   lx_mode;
  logic [1:0]  lx_bom;
  logic        lx_cr;
  logic        lx_dead;
  logic [15:0] lx_line;
  logic [15:0] lx_col;
  logic [15:0] lx_tok_line;
  logic [15:0] lx_tok_col;
  int          n_emitted;

  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_taken = 0;
  int unsigned n_offered = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic        sync_wait = 1'b0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_phase = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  config_text_tokenizer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lexer predictor

  function automatic void lex_clear();
    lx_mode     = M_BOM;
    lx_bom      = '0;
    lx_cr       = 1'b0;
    lx_dead     = 1'b0;
    lx_line     = 16'd1;
    lx_col      = 16'd1;
    lx_tok_line = 16'd1;
    lx_tok_col  = 16'd1;
  endfunction

  function automatic void emit(logic [1:0] ev, logic [3:0] kind, logic [7:0] val,
                               logic [15:0] ln, logic [15:0] cl, logic [1:0] err);
    ctt_out_t r;
    r            = '0;
    r.event_res  = ev;
    r.token_kind = kind;
    r.value_byte = val;
    r.line_no    = ln;
    r.column_no  = cl;
    r.error_code = err;
    token_events_q.insert(token_events_q.size(), r);
    n_emitted++;
  endfunction

  function automatic void fail_at(logic [1:0] err, logic [15:0] ln, logic [15:0] cl);
    emit(EV_ERROR, KIND_WORD, 8'h00, ln, cl, err);
    lx_dead = 1'b1;
  endfunction

  function automatic void advance_col();
    if (lx_col != PORT_POS_MAX) lx_col++;
  endfunction

  function automatic void advance_line();
    if (lx_line != PORT_POS_MAX) lx_line++;
    lx_col = 16'd1;
  endfunction

  function automatic void mark_token();
    lx_tok_line = lx_line;
    lx_tok_col  = lx_col;
  endfunction

  function automatic void word_byte_out(logic [7:0] b);
    emit(EV_CONTENT, KIND_WORD, b, lx_tok_line, lx_tok_col, ERR_NONE);
    advance_col();
  endfunction

  function automatic logic [3:0] punct_of(logic [7:0] b);
    case (b)
      CH_LBRACE:   return KIND_LBRACE;
      CH_RBRACE:   return KIND_RBRACE;
      CH_LBRACKET: return KIND_LBRACKET;
      CH_RBRACKET: return KIND_RBRACKET;
      CH_SEMI:     return KIND_SEMI;
      CH_COMMA:    return KIND_COMMA;
      default:     return KIND_WORD;
    endcase
  endfunction

  function automatic logic is_delim(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_QUOTE ||
           b == CH_HASH || punct_of(b) != KIND_WORD;
  endfunction

  function automatic void idle_byte(logic [7:0] b, logic after_cr);
    lx_mode = M_IDLE;
    if (b == CH_LF && after_cr) return;
    if (b == CH_SPACE || b == CH_TAB) begin
      advance_col();
    end else if (b == CH_CR) begin
      advance_line();
      lx_cr = 1'b1;
    end else if (b == CH_LF) begin
      advance_line();
    end else if (b == CH_HASH) begin
      lx_mode = M_CMT;
      advance_col();
    end else if (b == CH_QUOTE) begin
      mark_token();
      lx_mode = M_STR;
      advance_col();
    end else if (punct_of(b) != KIND_WORD) begin
      emit(EV_TOKEN, punct_of(b), 8'h00, lx_line, lx_col, ERR_NONE);
      advance_col();
    end else if (b < CTRL_LIMIT) begin
      fail_at(ERR_CTRL_WORD, lx_line, lx_col);
    end else begin
      mark_token();
      lx_mode = M_WORD;
      word_byte_out(b);
    end
  endfunction

  function automatic void replay_bom();
    if (lx_bom != 2'd0) begin
      lx_tok_line = 16'd1;
      lx_tok_col  = 16'd1;
      lx_mode     = M_WORD;
      word_byte_out(BOM_B0);
      if (lx_bom > 2'd1) word_byte_out(BOM_B1);
    end else begin
      lx_mode = M_IDLE;
    end
    lx_bom = 2'd0;
  endfunction

  function automatic void lex_data(logic [7:0] b);
    logic       after_cr;
    logic [7:0] v;
    after_cr = lx_cr;
    lx_cr    = 1'b0;
    if (lx_mode == M_BOM) begin
      if ((lx_bom == 2'd0 && b == BOM_B0) || (lx_bom == 2'd1 && b == BOM_B1)) begin
        lx_bom++;
        return;
      end
      if (lx_bom == 2'd2 && b == BOM_B2) begin
        lx_bom  = 2'd0;
        lx_mode = M_IDLE;
        return;
      end
      replay_bom();
    end
    case (lx_mode)
      M_WORD: begin
        if (is_delim(b)) begin
          emit(EV_TOKEN, KIND_WORD, 8'h00, lx_tok_line, lx_tok_col, ERR_NONE);
          idle_byte(b, 1'b0);
        end else if (b < CTRL_LIMIT) begin
          fail_at(ERR_CTRL_WORD, lx_line, lx_col);
        end else begin
          word_byte_out(b);
        end
      end
      M_STR: begin
        if (b == CH_QUOTE) begin
          emit(EV_TOKEN, KIND_STRING, 8'h00, lx_tok_line, lx_tok_col, ERR_NONE);
          advance_col();
          lx_mode = M_IDLE;
        end else if (b == CH_BSLASH) begin
          lx_mode = M_ESC;
        end else if (b < CTRL_LIMIT) begin
          fail_at(ERR_CTRL_STRING, lx_line, lx_col);
        end else begin
          emit(EV_CONTENT, KIND_STRING, b, lx_tok_line, lx_tok_col, ERR_NONE);
          advance_col();
        end
      end
      M_ESC: begin
        if (b == CH_QUOTE || b == CH_BSLASH) begin
          v = b;
        end else if (b == CH_N) begin
          v = CH_LF;
        end else if (b == CH_T) begin
          v = CH_TAB;
        end else begin
          fail_at(ERR_BAD_ESCAPE, lx_line, lx_col);
          return;
        end
        emit(EV_CONTENT, KIND_STRING, v, lx_tok_line, lx_tok_col, ERR_NONE);
        advance_col();
        advance_col();
        lx_mode = M_STR;
      end
      M_CMT: begin
        if (b == CH_CR || b == CH_LF) idle_byte(b, 1'b0);
        else advance_col();
      end
      default: begin
        idle_byte(b, after_cr);
      end
    endcase
  endfunction

  function automatic void lex_end();
    if (lx_mode == M_BOM) replay_bom();
    if (lx_mode == M_STR || lx_mode == M_ESC) begin
      fail_at(ERR_UNTERM_STR, lx_tok_line, lx_tok_col);
      return;
    end
    if (lx_mode == M_WORD) emit(EV_TOKEN, KIND_WORD, 8'h00, lx_tok_line, lx_tok_col, ERR_NONE);
    emit(EV_TOKEN, KIND_END, 8'h00, lx_line, lx_col, ERR_NONE);
    lex_clear();
  endfunction

  function automatic void tokenize_request(ctt_in_t r);
    ctt_out_t tail;
    n_emitted = 0;
    if (lx_dead) return;
    if (r.func == FUNC_END) lex_end();
    else lex_data(r.data_byte);
    if (n_emitted > 0) begin
      tail      = token_events_q.pop_back();
      tail.last = 1'b1;
      token_events_q.insert(token_events_q.size(), tail);
    end
  endfunction

  // Stimulus builders

  task automatic queue_byte(logic [7:0] b);
    text_item_t it;
    it.sync          = 1'b0;
    it.req.func      = FUNC_DATA;
    it.req.data_byte = b;
    text_q.insert(text_q.size(), it);
  endtask

  task automatic queue_end();
    text_item_t it;
    it.sync          = 1'b0;
    it.req.func      = FUNC_END;
    it.req.data_byte = 8'($urandom_range(0, 255));
    text_q.insert(text_q.size(), it);
  endtask

  task automatic queue_sync();
    text_item_t it;
    it      = '0;
    it.sync = 1'b1;
    text_q.insert(text_q.size(), it);
  endtask

  task automatic queue_string(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h21, 8'hFF)); while (is_delim(b));
    return b;
  endfunction

  function automatic logic [7:0] string_char();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = CH_TAB;
      1: b = ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
      default: do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE);
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ctrl_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 8'h1F)); while (b == CH_TAB || b == CH_LF || b == CH_CR);
    return b;
  endfunction

  task automatic queue_escape();
    queue_byte(CH_BSLASH);
    case ($urandom_range(0, 3))
      0: queue_byte(CH_QUOTE);
      1: queue_byte(CH_BSLASH);
      2: queue_byte(CH_N);
      default: queue_byte(CH_T);
    endcase
  endtask

  task automatic queue_random_text();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: begin
        queue_byte(BOM_B0);
        queue_byte(BOM_B1);
        queue_byte(BOM_B2);
      end
      1: begin
        queue_byte(BOM_B0);
        if ($urandom_range(0, 1) != 0) queue_byte(BOM_B1);
      end
      default: ;
    endcase
    repeat ($urandom_range(1, 14)) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: repeat ($urandom_range(1, 6)) queue_byte(word_char());
        4, 5: begin
          queue_byte(CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) queue_escape();
            else queue_byte(string_char());
          end
          queue_byte(CH_QUOTE);
        end
        6, 7: begin
          case ($urandom_range(0, 5))
            0: queue_byte(CH_LBRACE);
            1: queue_byte(CH_RBRACE);
            2: queue_byte(CH_LBRACKET);
            3: queue_byte(CH_RBRACKET);
            4: queue_byte(CH_SEMI);
            default: queue_byte(CH_COMMA);
          endcase
        end
        8, 9: begin
          case ($urandom_range(0, 4))
            0: queue_byte(CH_SPACE);
            1: queue_byte(CH_TAB);
            2: queue_byte(CH_CR);
            3: queue_byte(CH_LF);
            default: begin
              queue_byte(CH_CR);
              queue_byte(CH_LF);
            end
          endcase
        end
        10: begin
          queue_byte(CH_HASH);
          repeat ($urandom_range(0, 8)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
            queue_byte(b);
          end
          queue_byte(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        end
        default: queue_byte(noise_char());
      endcase
    end
    queue_end();
  endtask

  task automatic queue_error_text();
    logic [1:0] err;
    err = 2'($urandom_range(0, 3));
    queue_string("k ");
    case (err)
      ERR_CTRL_WORD: begin
        if ($urandom_range(0, 1) != 0) queue_byte(word_char());
        queue_byte(ctrl_char());
      end
      ERR_UNTERM_STR: begin
        queue_byte(CH_QUOTE);
        queue_byte(string_char());
        if ($urandom_range(0, 1) != 0) queue_byte(CH_BSLASH);
        queue_end();
      end
      ERR_BAD_ESCAPE: begin
        queue_byte(CH_QUOTE);
        queue_byte(CH_BSLASH);
        queue_byte(CH_SPACE);
      end
      default: begin
        queue_byte(CH_QUOTE);
        queue_byte(8'($urandom_range(0, 8'h1F)));
      end
    endcase
    repeat (6) queue_byte(noise_char());
    queue_end();
    queue_byte(word_char());
    queue_end();
  endtask

  // Sender: bursts with random gaps, hold payload until taken

  always @(negedge clk) begin : drive
    logic       nxt_valid;
    ctt_in_t    nxt_data;
    text_item_t it;
    nxt_valid = 1'b0;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (in_valid && n_taken != n_offered) begin
      nxt_valid = 1'b1;
    end else if (sync_wait) begin
      if (token_events_q.size() == 0) sync_wait = 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (text_q.size() > 0) begin
      it = text_q.pop_front();
      if (it.sync) begin
        sync_wait = 1'b1;
      end else begin
        nxt_valid = 1'b1;
        nxt_data  = it.req;
        n_offered++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Receiver: stall pattern changes every phase, one long hold-off

  always @(negedge clk) begin : receive
    logic nxt_stall;
    rx_phase++;
    if (rx_phase == 97) begin
      rx_phase = 0;
      rx_mode  = rx_mode_t'($urandom_range(0, 3));
    end
    if (!hold_done && n_checked >= 100 && in_valid) begin
      hold_done = 1'b1;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:  nxt_stall = 1'b0;
        RX_LIGHT: nxt_stall = ($urandom_range(0, 3) == 0);
        RX_HEAVY: nxt_stall = ($urandom_range(0, 3) != 0);
        default:  nxt_stall = (rx_phase % 3 != 0);
      endcase
    end
    out_stall <= nxt_stall;
  end

  // Accept requests, check results

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : observe
    ctt_out_t want;
    if (rst_n && in_valid && !in_stall) begin
      tokenize_request(in_data);
      n_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (token_events_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("%0t: result with none expected, expected none, got %h", $time, out_data);
      end else begin
        want = token_events_q.pop_front();
        check_field("event_res", 16'(want.event_res), 16'(out_data.event_res));
        check_field("token_kind", 16'(want.token_kind), 16'(out_data.token_kind));
        check_field("value_byte", 16'(want.value_byte), 16'(out_data.value_byte));
        check_field("line_no", want.line_no, out_data.line_no);
        check_field("column_no", want.column_no, out_data.column_no);
        check_field("error_code", 16'(want.error_code), 16'(out_data.error_code));
        check_field("last", 16'(want.last), 16'(out_data.last));
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("[config_text_tokenizer] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n_random;
    int unsigned mark;
    lex_clear();

    // full BOM, then word closed by a brace
    queue_byte(BOM_B0);
    queue_byte(BOM_B1);
    queue_byte(BOM_B2);
    queue_string("a{");
    queue_end();
    // two held BOM bytes replayed before a closing brace
    queue_byte(BOM_B0);
    queue_byte(BOM_B1);
    queue_byte(CH_RBRACE);
    queue_end();
    // one held BOM byte at end of input
    queue_byte(BOM_B0);
    queue_end();
    // string with all four escapes, comment with a control byte, CRLF, tab
    queue_string("\"\\\"\\\\\\n\\t\"");
    queue_byte(CH_COMMA);
    queue_byte(CH_HASH);
    queue_byte(8'h00);
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    queue_byte(8'hFF);
    queue_byte(CH_TAB);
    queue_end();
    queue_sync();

    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      mark = text_q.size();
      queue_random_text();
      n_random += text_q.size() - mark;
      if ($urandom_range(0, 5) == 0) queue_sync();
    end
    queue_sync();
    // sticky error closes the run
    queue_error_text();

    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_valid || sync_wait || token_events_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0 && token_events_q.size() == 0) begin
      $display("[config_text_tokenizer] OK");
    end else begin
      $display("[config_text_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
